FILE: hw/rtl/imcpt_pkg.sv
// Shared types and constants of the immediate-compare pulse timer.
`default_nettype none

package imcpt_pkg;

   // Request codes
   localparam logic [2:0] REQ_TICK     = 3'd0;
   localparam logic [2:0] REQ_SET_LEAD = 3'd1;
   localparam logic [2:0] REQ_START    = 3'd2;
   localparam logic [2:0] REQ_STOP     = 3'd3;
   localparam logic [2:0] REQ_STROBE   = 3'd4;

   // Hazard policy codes
   localparam logic [1:0] POLICY_FIRE = 2'd0;

   // Compare status codes
   localparam logic [1:0] STATUS_NONE      = 2'd0;
   localparam logic [1:0] STATUS_SCHEDULED = 2'd1;
   localparam logic [1:0] STATUS_HAZARD    = 2'd2;

   // Register indexes
   localparam logic [2:0] CSR_DIVIDER      = 3'd0;
   localparam logic [2:0] CSR_PERIOD       = 3'd1;
   localparam logic [2:0] CSR_WIDTH        = 3'd2;
   localparam logic [2:0] CSR_ONE_SHOT     = 3'd3;
   localparam logic [2:0] CSR_MULTISHOT    = 3'd4;
   localparam logic [2:0] CSR_TRIG_ENABLE  = 3'd5;
   localparam logic [2:0] CSR_TRIG_FALLING = 3'd6;

   localparam logic [16:0] MAX_DIVIDER    = 17'd65536;
   localparam logic [31:0] RESET_WIDTH    = 32'd200;
   localparam int          CSR_INDEX_BITS = 3;
   localparam int          CSR_DATA_BITS  = 32;

   typedef struct packed {
      logic [2:0]  req_type;
      logic [31:0] compare_ticks;
      logic [1:0]  hazard_policy;
      logic        trigger_level;
   } req_item_type;

   typedef struct packed {
      logic        strobe_level;
      logic        start_event;
      logic        mid_event;
      logic        term_event;
      logic [1:0]  compare_status;
      logic [31:0] count_value;
      logic        running;
   } rsp_item_type;

   // Effective (already clamped) configuration
   typedef struct packed {
      logic [16:0] divider;
      logic [31:0] period;
      logic [31:0] width;
      logic        one_shot;
      logic        trig_enable;
      logic        trig_falling;
   } cfg_type;

   // Register writes that touch timer state
   typedef struct packed {
      logic        divider_wr;
      logic        multishot_wr;
      logic [31:0] multishot_value;
   } csr_evt_type;

endpackage

`default_nettype wire

FILE: hw/rtl/imcpt_if.sv
// Valid/ready channel interfaces for timer requests and results.
`default_nettype none

interface imcpt_req_if;
   import imcpt_pkg::*;
   logic        valid;
   logic        ready;
   logic [2:0]  req_type;
   logic [31:0] compare_ticks;
   logic [1:0]  hazard_policy;
   logic        trigger_level;

   modport source (output valid, req_type, compare_ticks, hazard_policy, trigger_level,
                   input ready);
   modport sink   (input valid, req_type, compare_ticks, hazard_policy, trigger_level,
                   output ready);
endinterface

interface imcpt_rsp_if;
   import imcpt_pkg::*;
   logic        valid;
   logic        ready;
   logic        strobe_level;
   logic        start_event;
   logic        mid_event;
   logic        term_event;
   logic [1:0]  compare_status;
   logic [31:0] count_value;
   logic        running;

   modport source (output valid, strobe_level, start_event, mid_event, term_event,
                   compare_status, count_value, running, input ready);
   modport sink   (input valid, strobe_level, start_event, mid_event, term_event,
                   compare_status, count_value, running, output ready);
endinterface

`default_nettype wire

FILE: hw/rtl/imcpt_csr.sv
// Configuration registers of the pulse timer, stored in clamped form.
`default_nettype none

module imcpt_csr #(
   parameter int COUNT_WIDTH = 32
) (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic                                  csr_we,
   input  wire logic [imcpt_pkg::CSR_INDEX_BITS-1:0]  csr_index,
   input  wire logic [imcpt_pkg::CSR_DATA_BITS-1:0]   csr_wdata,
   output imcpt_pkg::cfg_type                         cfg,
   output imcpt_pkg::csr_evt_type                     evt
);
   import imcpt_pkg::*;

   localparam logic [31:0] COUNT_MASK = 32'((64'd1 << COUNT_WIDTH) - 64'd1);

   cfg_type     cfg_ff, cfg_in;
   logic [16:0] div_raw;

   // Clamp each value as it is written
   always_comb begin
      cfg_in  = cfg_ff;
      div_raw = csr_wdata[16:0];
      evt     = '0;
      evt.multishot_value = csr_wdata;
      if (csr_we) begin
         case (csr_index)
            CSR_DIVIDER: begin
               evt.divider_wr = 1'b1;
               if (div_raw == 17'd0)
                  cfg_in.divider = 17'd1;
               else if (div_raw > MAX_DIVIDER)
                  cfg_in.divider = MAX_DIVIDER;
               else
                  cfg_in.divider = div_raw;
            end
            CSR_PERIOD: begin
               if (csr_wdata == 32'd0)
                  cfg_in.period = 32'd1;
               else if (csr_wdata > COUNT_MASK)
                  cfg_in.period = COUNT_MASK;
               else
                  cfg_in.period = csr_wdata;
            end
            CSR_WIDTH: begin
               cfg_in.width = (csr_wdata == 32'd0) ? 32'd1 : csr_wdata;
            end
            CSR_ONE_SHOT: begin
               cfg_in.one_shot = csr_wdata[0];
            end
            CSR_MULTISHOT: begin
               evt.multishot_wr = 1'b1;
               cfg_in.one_shot  = 1'b0;
            end
            CSR_TRIG_ENABLE: begin
               cfg_in.trig_enable = csr_wdata[0];
            end
            CSR_TRIG_FALLING: begin
               cfg_in.trig_falling = csr_wdata[0];
            end
            default: begin
            end
         endcase
      end
   end

   // Hold configuration
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.divider      <= 17'd1;
         cfg_ff.period       <= COUNT_MASK;
         cfg_ff.width        <= RESET_WIDTH;
         cfg_ff.one_shot     <= 1'b0;
         cfg_ff.trig_enable  <= 1'b0;
         cfg_ff.trig_falling <= 1'b0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

`default_nettype wire

FILE: hw/rtl/imcpt_core.sv
// Timer state and the single-pass update for one request.
`default_nettype none

module imcpt_core #(
   parameter int COUNT_WIDTH = 32
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   step,
   input  wire imcpt_pkg::req_item_type item,
   input  wire imcpt_pkg::cfg_type     cfg,
   input  wire imcpt_pkg::csr_evt_type evt,
   output imcpt_pkg::rsp_item_type     result
);
   import imcpt_pkg::*;

   logic [COUNT_WIDTH-1:0] counter_ff, counter_in;
   logic [15:0]            phase_ff, phase_in;
   logic [COUNT_WIDTH-1:0] lead_ff, lead_in;
   logic [COUNT_WIDTH-1:0] trail_ff, trail_in;
   logic                   pin_ff, pin_in;
   logic                   enabled_ff, enabled_in;
   logic [31:0]            periods_left_ff, periods_left_in;
   logic                   last_trig_ff, last_trig_in;

   logic                   land_en;
   logic [COUNT_WIDTH-1:0] land_val;
   logic [COUNT_WIDTH-1:0] period_cnt;
   logic [16:0]            phase_sum;
   logic                   trig_edge;
   logic [31:0]            lead_clamp;
   logic [32:0]            trail_sum;
   logic [31:0]            trail_clamp;
   logic                   ev_start, ev_mid, ev_term;
   logic [1:0]             status;

   assign period_cnt = cfg.period[COUNT_WIDTH-1:0];

   // Work out the next state for the request in the input register
   always_comb begin
      counter_in      = counter_ff;
      phase_in        = phase_ff;
      lead_in         = lead_ff;
      trail_in        = trail_ff;
      pin_in          = pin_ff;
      enabled_in      = enabled_ff;
      periods_left_in = periods_left_ff;
      last_trig_in    = last_trig_ff;
      land_en         = 1'b0;
      land_val        = '0;
      ev_start        = 1'b0;
      ev_mid          = 1'b0;
      ev_term         = 1'b0;
      status          = STATUS_NONE;
      phase_sum       = {1'b0, phase_ff} + 17'd1;
      trig_edge       = cfg.trig_falling ? (last_trig_ff & ~item.trigger_level)
                                         : (~last_trig_ff & item.trigger_level);
      lead_clamp      = (item.compare_ticks > cfg.period) ? cfg.period : item.compare_ticks;
      trail_sum       = {1'b0, lead_clamp} + {1'b0, cfg.width};
      trail_clamp     = (trail_sum > {1'b0, cfg.period}) ? cfg.period : trail_sum[31:0];

      if (step) begin
         case (item.req_type)
            REQ_TICK: begin
               last_trig_in = item.trigger_level;
               if (enabled_ff) begin
                  if (cfg.trig_enable && trig_edge) begin
                     // Restart the period on the trigger edge
                     phase_in = 16'd0;
                     land_en  = 1'b1;
                  end else if (phase_sum >= cfg.divider) begin
                     phase_in = 16'd0;
                     land_en  = 1'b1;
                     if (counter_ff >= period_cnt) begin
                        // Roll over and count down the run length
                        ev_term = 1'b1;
                        if (cfg.one_shot)
                           enabled_in = 1'b0;
                        if (periods_left_ff != 32'd0) begin
                           periods_left_in = periods_left_ff - 32'd1;
                           if (periods_left_ff == 32'd1)
                              enabled_in = 1'b0;
                        end
                     end else begin
                        land_val = counter_ff + 1'b1;
                     end
                  end else begin
                     phase_in = phase_sum[15:0];
                  end
               end
            end
            REQ_SET_LEAD: begin
               lead_in  = lead_clamp[COUNT_WIDTH-1:0];
               trail_in = trail_clamp[COUNT_WIDTH-1:0];
               if (32'(counter_ff) < lead_clamp) begin
                  status = STATUS_SCHEDULED;
               end else begin
                  status = STATUS_HAZARD;
                  if (item.hazard_policy == POLICY_FIRE) begin
                     pin_in = 1'b0;
                     ev_mid = 1'b1;
                  end
               end
            end
            REQ_START: begin
               phase_in   = 16'd0;
               enabled_in = 1'b1;
               land_en    = 1'b1;
            end
            REQ_STOP: begin
               enabled_in = 1'b0;
            end
            REQ_STROBE: begin
               pin_in = 1'b0;
               ev_mid = 1'b1;
            end
            default: begin
            end
         endcase

         // New counter value: check both compares, trail wins the pin
         if (land_en) begin
            counter_in = land_val;
            ev_start   = (land_val == '0);
            if (land_val == lead_ff) begin
               pin_in = 1'b0;
               ev_mid = 1'b1;
            end
            if (land_val == trail_ff)
               pin_in = 1'b1;
         end
      end

      // Register writes that act on timer state
      if (evt.divider_wr)
         phase_in = 16'd0;
      if (evt.multishot_wr)
         periods_left_in = evt.multishot_value;
   end

   // Hold timer state
   always_ff @(posedge clock) begin
      if (reset) begin
         counter_ff      <= '0;
         phase_ff        <= 16'd0;
         lead_ff         <= '0;
         trail_ff        <= '0;
         pin_ff          <= 1'b1;
         enabled_ff      <= 1'b1;
         periods_left_ff <= 32'd0;
         last_trig_ff    <= 1'b0;
      end else begin
         counter_ff      <= counter_in;
         phase_ff        <= phase_in;
         lead_ff         <= lead_in;
         trail_ff        <= trail_in;
         pin_ff          <= pin_in;
         enabled_ff      <= enabled_in;
         periods_left_ff <= periods_left_in;
         last_trig_ff    <= last_trig_in;
      end
   end

   // Result reports the state after this request
   always_comb begin
      result.strobe_level   = pin_in;
      result.start_event    = ev_start;
      result.mid_event      = ev_mid;
      result.term_event     = ev_term;
      result.compare_status = status;
      result.count_value    = 32'(counter_in);
      result.running        = enabled_in;
   end

endmodule

`default_nettype wire

FILE: hw/rtl/immediate_compare_pulse_timer_top.sv
// Pulse timer top level: input register, timer core, result register.
// A request passes through the input register and the result register before its result is offered.
// Throughput: one request per cycle while results are taken; the timer core updates its state in one pass.
// A waiting result holds the core; the input register takes one more request, then stalls.
// Reset (synchronous, active high): counter 0, strobe high, counter running,
// registers at their defaults; pipeline empty.
`default_nettype none

module immediate_compare_pulse_timer_top #(
   parameter int COUNT_WIDTH = 32
) (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   imcpt_req_if.sink                                  req_bus,
   imcpt_rsp_if.source                                rsp_bus,
   input  wire logic                                  csr_we,
   input  wire logic [imcpt_pkg::CSR_INDEX_BITS-1:0]  csr_index,
   input  wire logic [imcpt_pkg::CSR_DATA_BITS-1:0]   csr_wdata
);
   import imcpt_pkg::*;

   req_item_type in_ff, in_in;
   logic         in_valid_ff, in_valid_in;
   rsp_item_type out_ff, out_in;
   logic         out_valid_ff, out_valid_in;
   logic         advance;
   logic         step;
   logic         req_xfer;
   cfg_type      cfg;
   csr_evt_type  evt;
   rsp_item_type core_result;

   imcpt_csr #(.COUNT_WIDTH(COUNT_WIDTH)) u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg),
      .evt       (evt)
   );

   imcpt_core #(.COUNT_WIDTH(COUNT_WIDTH)) u_core (
      .clock  (clock),
      .reset  (reset),
      .step   (step),
      .item   (in_ff),
      .cfg    (cfg),
      .evt    (evt),
      .result (core_result)
   );

   // Handshake: advance when the result register is free or being drained
   assign advance       = ~out_valid_ff | rsp_bus.ready;
   assign step          = in_valid_ff & advance;
   assign req_bus.ready = ~in_valid_ff | advance;
   assign req_xfer      = req_bus.valid & req_bus.ready;

   always_comb begin
      in_in               = in_ff;
      in_valid_in         = in_valid_ff & ~advance;
      out_in              = out_ff;
      out_valid_in        = out_valid_ff & ~rsp_bus.ready;
      if (req_xfer) begin
         in_in.req_type      = req_bus.req_type;
         in_in.compare_ticks = req_bus.compare_ticks;
         in_in.hazard_policy = req_bus.hazard_policy;
         in_in.trigger_level = req_bus.trigger_level;
         in_valid_in         = 1'b1;
      end
      if (step) begin
         out_in       = core_result;
         out_valid_in = 1'b1;
      end
   end

   // Hold pipeline registers
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
      in_ff  <= in_in;
      out_ff <= out_in;
   end

   // Drive the result channel
   assign rsp_bus.valid          = out_valid_ff;
   assign rsp_bus.strobe_level   = out_ff.strobe_level;
   assign rsp_bus.start_event    = out_ff.start_event;
   assign rsp_bus.mid_event      = out_ff.mid_event;
   assign rsp_bus.term_event     = out_ff.term_event;
   assign rsp_bus.compare_status = out_ff.compare_status;
   assign rsp_bus.count_value    = out_ff.count_value;
   assign rsp_bus.running        = out_ff.running;

endmodule

`default_nettype wire

FILE: tb/testbench.sv
// Self-checking testbench for the immediate-compare pulse timer top level.
`default_nettype none

module testbench;
   import imcpt_pkg::*;

   // Codes the package leaves unnamed
   localparam logic [1:0] POLICY_SKIP   = 2'd1;
   localparam logic [1:0] POLICY_WRAP   = 2'd2;
   localparam logic [1:0] POLICY_SPARE  = 2'd3;
   localparam logic [2:0] REQ_SPARE_LO  = 3'd5;
   localparam logic [2:0] REQ_SPARE_MID = 3'd6;
   localparam logic [2:0] REQ_SPARE_HI  = 3'd7;
   localparam logic [2:0] CSR_UNUSED    = 3'd7;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        csr_we = 1'b0;
   logic [2:0]  csr_index = CSR_DIVIDER;
   logic [31:0] csr_wdata = 32'd0;

   imcpt_req_if req_ch ();
   imcpt_rsp_if rsp_ch ();

   immediate_compare_pulse_timer_top dut (
      .clock     (clock),
      .reset     (reset),
      .req_bus   (req_ch),
      .rsp_bus   (rsp_ch),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Timer model state and register copies
   logic [31:0] tm_counter, tm_lead, tm_trail, tm_periods_left;
   int unsigned tm_phase;
   logic        tm_pin, tm_running, tm_last_trig;
   logic [16:0] cfg_divider;
   logic [31:0] cfg_period, cfg_width;
   logic        cfg_one_shot, cfg_trig_en, cfg_trig_falling;
   logic        ev_start, ev_mid, ev_term;

   req_item_type pending_reqs[$];
   rsp_item_type timer_results_due[$];
   req_item_type cur_req;
   int unsigned  idle_pct = 19;
   int unsigned  errors = 0;
   int unsigned  results_taken = 0;
   int unsigned  starve_left = 0;
   logic         starved_once = 1'b0;
   logic         gen_trig = 1'b0;

   function automatic logic [31:0] eff_period();
      return (cfg_period == 32'd0) ? 32'd1 : cfg_period;
   endfunction

   function automatic int unsigned eff_divider();
      if (cfg_divider == 17'd0) return 1;
      if (cfg_divider > MAX_DIVIDER) return 32'(MAX_DIVIDER);
      return 32'(cfg_divider);
   endfunction

   // Counter takes a new value: lead and trail compares act, trail wins the pin
   function automatic void land_count(logic [31:0] value);
      tm_counter = value;
      if (value == 32'd0) ev_start = 1'b1;
      if (value == tm_lead) begin
         tm_pin = 1'b0;
         ev_mid = 1'b1;
      end
      if (value == tm_trail) tm_pin = 1'b1;
   endfunction

   function automatic void apply_csr(logic [2:0] idx, logic [31:0] data);
      case (idx)
         CSR_DIVIDER: begin
            cfg_divider = data[16:0];
            tm_phase = 0;
         end
         CSR_PERIOD:       cfg_period = data;
         CSR_WIDTH:        cfg_width = data;
         CSR_ONE_SHOT:     cfg_one_shot = data[0];
         CSR_MULTISHOT: begin
            tm_periods_left = data;
            cfg_one_shot = 1'b0;
         end
         CSR_TRIG_ENABLE:  cfg_trig_en = data[0];
         CSR_TRIG_FALLING: cfg_trig_falling = data[0];
         default: ;
      endcase
   endfunction

   function automatic void reset_timer_model();
      cfg_divider = 17'd1;
      cfg_period = 32'hFFFF_FFFF;
      cfg_width = RESET_WIDTH;
      cfg_one_shot = 1'b0;
      cfg_trig_en = 1'b0;
      cfg_trig_falling = 1'b0;
      tm_counter = 32'd0;
      tm_phase = 0;
      tm_lead = 32'd0;
      tm_trail = 32'd0;
      tm_pin = 1'b1;
      tm_running = 1'b1;
      tm_periods_left = 32'd0;
      tm_last_trig = 1'b0;
   endfunction

   // Advance the timer model by one request and return the result it owes
   function automatic rsp_item_type step_timer_model(req_item_type r);
      rsp_item_type res;
      logic [32:0]  trail_sum;
      logic [31:0]  lead, width;
      logic         edge_hit;
      logic [1:0]   status;
      status = STATUS_NONE;
      ev_start = 1'b0;
      ev_mid = 1'b0;
      ev_term = 1'b0;
      case (r.req_type)
         REQ_TICK: begin
            edge_hit = cfg_trig_falling ? (tm_last_trig && !r.trigger_level)
                                        : (!tm_last_trig && r.trigger_level);
            tm_last_trig = r.trigger_level;
            if (tm_running) begin
               if (cfg_trig_en && edge_hit) begin
                  tm_phase = 0;
                  land_count(32'd0);
               end else begin
                  tm_phase++;
                  if (tm_phase >= eff_divider()) begin
                     tm_phase = 0;
                     if (tm_counter >= eff_period()) begin
                        ev_term = 1'b1;
                        if (cfg_one_shot) tm_running = 1'b0;
                        if (tm_periods_left != 32'd0) begin
                           tm_periods_left--;
                           if (tm_periods_left == 32'd0) tm_running = 1'b0;
                        end
                        land_count(32'd0);
                     end else begin
                        land_count(tm_counter + 32'd1);
                     end
                  end
               end
            end
         end
         REQ_SET_LEAD: begin
            lead = (r.compare_ticks > eff_period()) ? eff_period() : r.compare_ticks;
            width = (cfg_width == 32'd0) ? 32'd1 : cfg_width;
            tm_lead = lead;
            trail_sum = {1'b0, lead} + {1'b0, width};
            tm_trail = (trail_sum > {1'b0, eff_period()}) ? eff_period() : trail_sum[31:0];
            if (tm_counter < lead) begin
               status = STATUS_SCHEDULED;
            end else begin
               status = STATUS_HAZARD;
               if (r.hazard_policy == POLICY_FIRE) begin
                  tm_pin = 1'b0;
                  ev_mid = 1'b1;
               end
            end
         end
         REQ_START: begin
            tm_phase = 0;
            tm_running = 1'b1;
            land_count(32'd0);
         end
         REQ_STOP: tm_running = 1'b0;
         REQ_STROBE: begin
            tm_pin = 1'b0;
            ev_mid = 1'b1;
         end
         default: ;
      endcase
      res.strobe_level = tm_pin;
      res.start_event = ev_start;
      res.mid_event = ev_mid;
      res.term_event = ev_term;
      res.compare_status = status;
      res.count_value = tm_counter;
      res.running = tm_running;
      return res;
   endfunction

   // Drive requests; predict each one at its transfer
   always @(posedge clock) begin : req_driver
      if (reset) begin
         req_ch.valid <= 1'b0;
      end else begin
         if (req_ch.valid && req_ch.ready)
            timer_results_due.push_back(step_timer_model(cur_req));
         if (!req_ch.valid || req_ch.ready) begin
            if (pending_reqs.size() != 0 && $urandom_range(0, 99) >= idle_pct) begin
               cur_req = pending_reqs.pop_front();
               req_ch.valid <= 1'b1;
               req_ch.req_type <= cur_req.req_type;
               req_ch.compare_ticks <= cur_req.compare_ticks;
               req_ch.hazard_policy <= cur_req.hazard_policy;
               req_ch.trigger_level <= cur_req.trigger_level;
            end else begin
               req_ch.valid <= 1'b0;
            end
         end
      end
   end

   task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
         $display("%0t: %s expected %0h got %0h", $time, name, want, got);
         errors++;
      end
   endtask

   // Check each result transfer against the oldest prediction; throttle ready
   always @(posedge clock) begin : rsp_monitor
      rsp_item_type want;
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            results_taken++;
            if (timer_results_due.size() == 0) begin
               $display("%0t: result with none expected, count %0h", $time,
                        rsp_ch.count_value);
               errors++;
            end else begin
               want = timer_results_due.pop_front();
               check_field("strobe_level", 32'(want.strobe_level),
                           32'(rsp_ch.strobe_level));
               check_field("start_event", 32'(want.start_event),
                           32'(rsp_ch.start_event));
               check_field("mid_event", 32'(want.mid_event), 32'(rsp_ch.mid_event));
               check_field("term_event", 32'(want.term_event), 32'(rsp_ch.term_event));
               check_field("compare_status", 32'(want.compare_status),
                           32'(rsp_ch.compare_status));
               check_field("count_value", want.count_value, rsp_ch.count_value);
               check_field("running", 32'(want.running), 32'(rsp_ch.running));
            end
         end
         // Hold off once for a long stretch so the pipeline backs up
         if (starve_left != 0) begin
            starve_left--;
            rsp_ch.ready <= 1'b0;
         end else if (!starved_once && results_taken >= 500) begin
            starve_left = 120;
            starved_once = 1'b1;
            rsp_ch.ready <= 1'b0;
         end else begin
            rsp_ch.ready <= ($urandom_range(0, 99) >= idle_pct);
         end
      end
   end

   function automatic req_item_type make_req(logic [2:0] kind, logic [31:0] ticks,
                                             logic [1:0] policy, logic level);
      req_item_type r;
      r.req_type = kind;
      r.compare_ticks = ticks;
      r.hazard_policy = policy;
      r.trigger_level = level;
      return r;
   endfunction

   // Mostly ticks, with lead moves near the counter range and the rest mixed in
   function automatic req_item_type make_random_req(int unsigned span);
      int unsigned  pick;
      logic [2:0]   kind;
      logic [31:0]  ticks;
      pick = $urandom_range(0, 99);
      if (pick < 62)      kind = REQ_TICK;
      else if (pick < 78) kind = REQ_SET_LEAD;
      else if (pick < 86) kind = REQ_START;
      else if (pick < 90) kind = REQ_STOP;
      else if (pick < 95) kind = REQ_STROBE;
      else                kind = 3'($urandom_range(REQ_SPARE_LO, REQ_SPARE_HI));
      ticks = ($urandom_range(0, 7) == 0) ? $urandom() : $urandom_range(0, span);
      if ($urandom_range(0, 9) == 0) gen_trig = !gen_trig;
      return make_req(kind, ticks, 2'($urandom_range(0, 3)), gen_trig);
   endfunction

   task automatic write_csr(logic [2:0] idx, logic [31:0] data);
      @(posedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      apply_csr(idx, data);
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   // Wait until every request is sent and answered, then let the pipeline settle
   task automatic wait_drained();
      do @(negedge clock);
      while (pending_reqs.size() != 0 || req_ch.valid || timer_results_due.size() != 0);
      repeat (4) @(posedge clock);
   endtask

   // One setting of all registers followed by a random run
   task automatic run_phase(logic [31:0] divider, logic [31:0] period, logic [31:0] width,
                            logic one_shot, logic [31:0] multishot, logic trig_en,
                            logic trig_falling, int unsigned count, int unsigned span);
      write_csr(CSR_DIVIDER, divider);
      write_csr(CSR_PERIOD, period);
      write_csr(CSR_WIDTH, width);
      write_csr(CSR_MULTISHOT, multishot);
      write_csr(CSR_ONE_SHOT, {31'd0, one_shot});
      write_csr(CSR_TRIG_ENABLE, {31'd0, trig_en});
      write_csr(CSR_TRIG_FALLING, {31'd0, trig_falling});
      repeat (count) pending_reqs.push_back(make_random_req(span));
      wait_drained();
   endtask

   initial begin
      req_ch.valid = 1'b0;
      req_ch.req_type = REQ_TICK;
      req_ch.compare_ticks = 32'd0;
      req_ch.hazard_policy = POLICY_FIRE;
      req_ch.trigger_level = 1'b0;
      rsp_ch.ready = 1'b0;
      reset_timer_model();
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // Directed: default registers, every request kind and hazard policy
      pending_reqs.push_back(make_req(REQ_TICK, 32'd0, POLICY_FIRE, 1'b0));
      pending_reqs.push_back(make_req(REQ_TICK, 32'hFFFF_FFFF, POLICY_SPARE, 1'b1));
      pending_reqs.push_back(make_req(REQ_SET_LEAD, 32'd0, POLICY_FIRE, 1'b0));
      pending_reqs.push_back(make_req(REQ_SET_LEAD, 32'hFFFF_FFFF, POLICY_SKIP, 1'b0));
      pending_reqs.push_back(make_req(REQ_SET_LEAD, 32'd3, POLICY_WRAP, 1'b0));
      pending_reqs.push_back(make_req(REQ_TICK, 32'd0, POLICY_FIRE, 1'b0));
      pending_reqs.push_back(make_req(REQ_SET_LEAD, 32'd3, POLICY_SPARE, 1'b0));
      pending_reqs.push_back(make_req(REQ_SET_LEAD, 32'd2, POLICY_SKIP, 1'b1));
      pending_reqs.push_back(make_req(REQ_SET_LEAD, 32'd1, POLICY_WRAP, 1'b0));
      pending_reqs.push_back(make_req(REQ_SET_LEAD, 32'd3, POLICY_FIRE, 1'b0));
      pending_reqs.push_back(make_req(REQ_STROBE, 32'd0, POLICY_FIRE, 1'b0));
      pending_reqs.push_back(make_req(REQ_STOP, 32'd0, POLICY_FIRE, 1'b0));
      pending_reqs.push_back(make_req(REQ_TICK, 32'd0, POLICY_FIRE, 1'b1));
      pending_reqs.push_back(make_req(REQ_SPARE_LO, 32'd0, POLICY_FIRE, 1'b0));
      pending_reqs.push_back(make_req(REQ_SPARE_MID, 32'hA5A5_5A5A, POLICY_SKIP, 1'b1));
      pending_reqs.push_back(make_req(REQ_SPARE_HI, 32'd0, POLICY_SPARE, 1'b0));
      pending_reqs.push_back(make_req(REQ_START, 32'd0, POLICY_FIRE, 1'b0));
      pending_reqs.push_back(make_req(REQ_TICK, 32'd0, POLICY_FIRE, 1'b0));
      pending_reqs.push_back(make_req(REQ_SET_LEAD, 32'd5, POLICY_FIRE, 1'b0));
      repeat (6) pending_reqs.push_back(make_req(REQ_TICK, 32'd0, POLICY_FIRE, 1'b0));
      wait_drained();

      // Short period with rising trigger, no idling on either side
      idle_pct = 0;
      run_phase(32'd1, 32'd10, 32'd3, 1'b0, 32'd0, 1'b1, 1'b0, 260, 12);
      idle_pct = 19;
      write_csr(CSR_UNUSED, 32'hFFFF_FFFF);
      // Zero divider, period and width act as one; falling trigger
      run_phase(32'd0, 32'd0, 32'd0, 1'b0, 32'd0, 1'b1, 1'b1, 200, 3);
      // Widest pulse clamps to the period; one-shot stop
      run_phase(32'd3, 32'd20, 32'hFFFF_FFFF, 1'b1, 32'd0, 1'b0, 1'b0, 260, 24);
      // Multishot run of four periods
      run_phase(32'd2, 32'd6, 32'd2, 1'b0, 32'd4, 1'b1, 1'b1, 260, 8);
      // Largest divider and full period
      run_phase(32'h0001_FFFF, 32'hFFFF_FFFF, 32'd1, 1'b0, 32'd0, 1'b0, 1'b0, 60, 40);
      // Largest multishot count, huge width
      run_phase(32'd1, 32'd7, 32'h8000_0000, 1'b0, 32'hFFFF_FFFF, 1'b1, 1'b0, 260, 9);
      run_phase(32'd5, 32'd100, 32'd50, 1'b1, 32'd0, 1'b1, 1'b1, 250, 110);

      repeat (6) @(posedge clock);
      if (errors == 0 && timer_results_due.size() == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

   // Hard stop in case the handshake hangs
   initial begin
      #3000000;
      $display("tb: failure");
      $finish;
   end

endmodule

`default_nettype wire
